@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/mtfc_pkg.sv @@
// package for the move-to-front coder: sizes, codes and cell control
`timescale 1ns / 1ps
`default_nettype none

package mtfc_pkg;

	localparam int ALPHABET_SIZE = 256;
	localparam int SYM_W = 8;
	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam int LEN_W = $clog2(ALPHABET_SIZE + 1);
	localparam int WIDE_W = (LEN_W > SYM_W) ? LEN_W : SYM_W;
	localparam int GRP = 16;
	localparam int GRP_W = $clog2(GRP);
	localparam int NGRP = (ALPHABET_SIZE + GRP - 1) / GRP;
	localparam int NCELL_PAD = NGRP * GRP;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_ENCODE = 2'd2,
		MODE_DECODE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_RANGE  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic             probe;
		logic             shift;
		logic             write;
		logic             decode;
		logic [SYM_W-1:0] operand;
		logic [IDX_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/move_to_front_coder_unit.sv @@
// move-to-front coder top level: cell chain, group reduce and sequencer
// clear and append: accept leads straight to the commit state, which writes the result
// encode and decode: accept leads through the probe, group reduce, merge and commit
// states; commit waits while the output is stalled; one word is worked on at a time
// a new word is taken while the previous result still waits in the output register
// reset empties the list and the output; symbol cells are not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module move_to_front_coder_unit
	import mtfc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       mode,
	input  wire logic [SYM_W-1:0] operand,
	input  wire logic             last,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [SYM_W-1:0] value,
	output logic      [1:0]       status,
	output logic                  last_out
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CELL,
		S_GROUP,
		S_MERGE,
		S_COMMIT
	} state_t;

	state_t           state_q;
	mode_t            mode_q;
	logic [SYM_W-1:0] operand_q;
	logic             last_q;
	logic [LEN_W-1:0] len_q;
	logic             found_q;
	logic [IDX_W-1:0] pos_q;
	logic [SYM_W-1:0] data_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] value_q;
	status_t          status_q;
	logic             last_out_q;

	logic             accept;
	logic             go;
	logic             full;
	logic [SYM_W-1:0] held;
	logic [SYM_W-1:0] c_value;
	status_t          c_status;
	logic             c_write;
	logic             c_shift;
	cell_ctl_t        ctl;

	logic [SYM_W-1:0] sym_w  [ALPHABET_SIZE];
	logic [SYM_W-1:0] prev_w [ALPHABET_SIZE];
	logic [NCELL_PAD-1:0]            hit_pad;
	logic [NCELL_PAD-1:0][SYM_W-1:0] data_pad;

	logic [NGRP-1:0]  grp_any;
	logic [GRP_W-1:0] grp_first  [NGRP];
	logic [SYM_W-1:0] grp_merged [NGRP];
	logic             m_found;
	logic [IDX_W-1:0] m_pos;
	logic [SYM_W-1:0] m_data;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign go       = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);
	assign full     = (len_q == LEN_W'(ALPHABET_SIZE));
	assign held     = (mode_q == MODE_DECODE) ? data_q : operand_q;

	always_comb begin
		c_value  = '0;
		c_status = ST_OK;
		c_write  = 1'b0;
		c_shift  = 1'b0;
		case (mode_q)
			MODE_CLEAR: begin
				c_status = ST_OK;
			end
			MODE_APPEND: begin
				if (full) begin
					c_status = ST_FULL;
				end else begin
					c_write = 1'b1;
				end
			end
			MODE_ENCODE: begin
				if (found_q) begin
					c_value = SYM_W'(pos_q);
					c_shift = 1'b1;
				end else begin
					c_status = ST_ABSENT;
				end
			end
			MODE_DECODE: begin
				if (found_q) begin
					c_value = data_q;
					c_shift = 1'b1;
				end else begin
					c_status = ST_RANGE;
				end
			end
			default: begin
				c_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		ctl.probe   = (state_q == S_CELL);
		ctl.shift   = go && c_shift;
		ctl.write   = go && c_write;
		ctl.decode  = (mode_q == MODE_DECODE);
		ctl.operand = operand_q;
		ctl.pos     = pos_q;
		ctl.len     = len_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < ALPHABET_SIZE; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign prev_w[gi] = held;
			end else begin : g_body
				assign prev_w[gi] = sym_w[gi-1];
			end
			mtfc_cell u_cell (
				.clk      (clk),
				.idx      (IDX_W'(gi)),
				.ctl      (ctl),
				.prev_sym (prev_w[gi]),
				.sym      (sym_w[gi]),
				.hit      (hit_pad[gi]),
				.data     (data_pad[gi])
			);
		end
		for (gi = ALPHABET_SIZE; gi < NCELL_PAD; gi++) begin : g_pad
			assign hit_pad[gi]  = 1'b0;
			assign data_pad[gi] = '0;
		end
		for (gi = 0; gi < NGRP; gi++) begin : g_grp
			mtfc_group u_group (
				.clk    (clk),
				.en     (state_q == S_GROUP),
				.hit    (hit_pad[gi*GRP +: GRP]),
				.data   (data_pad[gi*GRP +: GRP]),
				.any    (grp_any[gi]),
				.first  (grp_first[gi]),
				.merged (grp_merged[gi])
			);
		end
	endgenerate

	always_comb begin
		m_found = 1'b0;
		m_pos   = '0;
		m_data  = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				m_found = 1'b1;
				m_pos   = IDX_W'(g * GRP) + IDX_W'(grp_first[g]);
			end
			m_data = m_data | grp_merged[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= mode_t'(mode);
						operand_q <= operand;
						last_q    <= last;
						if ((mode_t'(mode) == MODE_ENCODE) || (mode_t'(mode) == MODE_DECODE)) begin
							state_q <= S_CELL;
						end else begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_CELL: begin
					state_q <= S_GROUP;
				end
				S_GROUP: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					found_q <= m_found;
					pos_q   <= m_pos;
					data_q  <= m_data;
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (go) begin
						value_q     <= c_value;
						status_q    <= c_status;
						last_out_q  <= last_q;
						if (mode_q == MODE_CLEAR) begin
							len_q <= '0;
						end else if (c_write) begin
							len_q <= len_q + LEN_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;
	assign last_out  = last_out_q;

	`ASSERT_IMP(a_len_bound, 1'b1, len_q <= LEN_W'(ALPHABET_SIZE))
	`ASSERT_IMP(a_out_from_commit, out_valid_q && !$past(out_valid_q), $past(state_q == S_COMMIT))
	`ASSERT_IMP(a_hit_in_list, (state_q == S_COMMIT) && c_shift, WIDE_W'(pos_q) < WIDE_W'(len_q))
	`ASSERT_NXT(a_accept_busy, accept, state_q != S_IDLE)

endmodule

`default_nettype wire

@@ hdl/mtfc_cell.sv @@
// one list cell: holds a symbol, probes it, shifts from its neighbor and takes an appended symbol
`timescale 1ns / 1ps
`default_nettype none

module mtfc_cell
	import mtfc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] idx,
	input  wire cell_ctl_t        ctl,
	input  wire logic [SYM_W-1:0] prev_sym,
	output logic      [SYM_W-1:0] sym,
	output logic                  hit,
	output logic      [SYM_W-1:0] data
);

	logic [SYM_W-1:0] sym_q;
	logic             hit_s1;
	logic [SYM_W-1:0] data_s1;
	logic             in_list;
	logic             hit_c;

	always_comb begin
		in_list = WIDE_W'(idx) < WIDE_W'(ctl.len);
		if (ctl.decode) begin
			hit_c = in_list && (WIDE_W'(idx) == WIDE_W'(ctl.operand));
		end else begin
			hit_c = in_list && (sym_q == ctl.operand);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.probe) begin
			hit_s1  <= hit_c;
			data_s1 <= hit_c ? sym_q : '0;
		end
		if (ctl.shift && (idx <= ctl.pos)) begin
			sym_q <= prev_sym;
		end else if (ctl.write && (WIDE_W'(idx) == WIDE_W'(ctl.len))) begin
			sym_q <= ctl.operand;
		end
	end

	assign sym  = sym_q;
	assign hit  = hit_s1;
	assign data = data_s1;

endmodule

`default_nettype wire

@@ hdl/mtfc_group.sv @@
// reduce one group of cells: first hit position and merged data
`timescale 1ns / 1ps
`default_nettype none

module mtfc_group
	import mtfc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [GRP-1:0]            hit,
	input  wire logic [GRP-1:0][SYM_W-1:0] data,
	output logic                           any,
	output logic      [GRP_W-1:0]          first,
	output logic      [SYM_W-1:0]          merged
);

	logic             any_s2;
	logic [GRP_W-1:0] first_s2;
	logic [SYM_W-1:0] merged_s2;
	logic [GRP_W-1:0] first_c;
	logic [SYM_W-1:0] merged_c;

	always_comb begin
		first_c  = '0;
		merged_c = '0;
		for (int k = GRP - 1; k >= 0; k--) begin
			if (hit[k]) begin
				first_c = GRP_W'(k);
			end
			merged_c = merged_c | data[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			any_s2    <= |hit;
			first_s2  <= first_c;
			merged_s2 <= merged_c;
		end
	end

	assign any    = any_s2;
	assign first  = first_s2;
	assign merged = merged_s2;

endmodule

`default_nettype wire

@@ tb/move_to_front_coder_unit_tb.sv @@
// testbench for move_to_front_coder_unit: directed table, then random list loads and coding runs
`timescale 1ns / 1ps

module move_to_front_coder_unit_tb;
	import mtfc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int NUM_ROWS = 20;
	localparam int RANDOM_WORDS = 800;

	typedef struct packed {
		logic [SYM_W-1:0] value;
		status_t          status;
		logic             last;
	} code_t;

	typedef struct packed {
		mode_t            m;
		logic [SYM_W-1:0] op;
		logic             l;
		logic             typed;
		logic [SYM_W-1:0] value;
		status_t          status;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       mode = MODE_CLEAR;
	logic [SYM_W-1:0] operand = '0;
	logic             last = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [SYM_W-1:0] value;
	logic [1:0]       status;
	logic             last_out;

	logic [SYM_W-1:0] mtf_list [ALPHABET_SIZE];
	logic [LEN_W-1:0] mtf_len = '0;
	code_t            pending_codes [$];
	int               mismatches = 0;
	int               sent = 0;
	int               cycles = 0;
	int               send_idle_pct = 34;
	int               recv_stall_pct = 65;

	row_t dir_rows [NUM_ROWS] = '{
		'{MODE_DECODE, 8'd0,   1'b0, 1'b1, 8'd0, ST_RANGE},
		'{MODE_ENCODE, 8'd0,   1'b0, 1'b1, 8'd0, ST_ABSENT},
		'{MODE_APPEND, 8'd255, 1'b0, 1'b1, 8'd0, ST_OK},
		'{MODE_APPEND, 8'd0,   1'b0, 1'b1, 8'd0, ST_OK},
		'{MODE_APPEND, 8'd7,   1'b0, 1'b1, 8'd0, ST_OK},
		'{MODE_APPEND, 8'd7,   1'b0, 1'b1, 8'd0, ST_OK},
		'{MODE_APPEND, 8'd128, 1'b0, 1'b1, 8'd0, ST_OK},
		'{MODE_ENCODE, 8'd255, 1'b0, 1'b1, 8'd0, ST_OK},
		'{MODE_ENCODE, 8'd7,   1'b0, 1'b0, 8'd0, ST_OK},
		'{MODE_DECODE, 8'd4,   1'b0, 1'b0, 8'd0, ST_OK},
		'{MODE_DECODE, 8'd5,   1'b0, 1'b1, 8'd0, ST_RANGE},
		'{MODE_DECODE, 8'd255, 1'b0, 1'b1, 8'd0, ST_RANGE},
		'{MODE_ENCODE, 8'd200, 1'b0, 1'b1, 8'd0, ST_ABSENT},
		'{MODE_DECODE, 8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
		'{MODE_ENCODE, 8'd0,   1'b1, 1'b0, 8'd0, ST_OK},
		'{MODE_CLEAR,  8'd0,   1'b1, 1'b1, 8'd0, ST_OK},
		'{MODE_ENCODE, 8'd7,   1'b0, 1'b1, 8'd0, ST_ABSENT},
		'{MODE_DECODE, 8'd0,   1'b0, 1'b1, 8'd0, ST_RANGE},
		'{MODE_APPEND, 8'd0,   1'b0, 1'b1, 8'd0, ST_OK},
		'{MODE_DECODE, 8'd0,   1'b1, 1'b0, 8'd0, ST_OK}
	};

	move_to_front_coder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.operand   (operand),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status),
		.last_out  (last_out)
	);

	always #2 clk = ~clk;

	// expected code for one word; updates the list copy
	function automatic code_t mtf_code(input mode_t m, input logic [SYM_W-1:0] op,
		input logic l);
		code_t            res;
		int               pos;
		int               i;
		logic [SYM_W-1:0] held;
		res = '{value: '0, status: ST_OK, last: l};
		pos = -1;
		case (m)
			MODE_CLEAR: begin
				mtf_len = '0;
			end
			MODE_APPEND: begin
				if (int'(mtf_len) >= ALPHABET_SIZE) begin
					res.status = ST_FULL;
				end else begin
					mtf_list[IDX_W'(mtf_len)] = op;
					mtf_len = mtf_len + 1'b1;
				end
			end
			MODE_ENCODE: begin
				res.status = ST_ABSENT;
				for (i = 0; i < int'(mtf_len); i++) begin
					if (mtf_list[IDX_W'(i)] == op) begin
						pos = i;
						break;
					end
				end
				if (pos >= 0) begin
					res.status = ST_OK;
					res.value = pos[SYM_W-1:0];
				end
			end
			default: begin
				if (int'(op) >= int'(mtf_len)) begin
					res.status = ST_RANGE;
				end else begin
					pos = int'(op);
					res.value = mtf_list[op];
				end
			end
		endcase
		if (pos > 0) begin
			held = mtf_list[IDX_W'(pos)];
			for (i = pos; i > 0; i--)
				mtf_list[IDX_W'(i)] = mtf_list[IDX_W'(i-1)];
			mtf_list[0] = held;
		end
		return res;
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input mode_t m, input logic [SYM_W-1:0] op, input logic l,
		input logic typed, input code_t typed_code);
		code_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		want = mtf_code(m, op, l);
		pending_codes.push_back(typed ? typed_code : want);
		in_valid <= 1'b1;
		mode <= m;
		operand <= op;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_codes();
		if (pending_codes.size() != 0) begin
			in_valid <= 1'b0;
			while (pending_codes.size() != 0)
				@(negedge clk);
		end
	endtask

	// optional clear, a list load, then a run of mostly encode and decode words
	task automatic code_sequence(input int fill);
		int               n_code;
		int               k;
		int               r;
		logic [SYM_W-1:0] op;
		mode_t            m;
		if ($urandom_range(9) != 0)
			send_word(MODE_CLEAR, SYM_W'($urandom), 1'b0, 1'b0, '0);
		if (fill == ALPHABET_SIZE)
			fill += $urandom_range(1, 3);
		for (k = 0; k < fill; k++) begin
			if (mtf_len != 0 && $urandom_range(3) == 0)
				op = mtf_list[IDX_W'($urandom_range(int'(mtf_len) - 1))];
			else
				op = SYM_W'($urandom);
			send_word(MODE_APPEND, op, 1'b0, 1'b0, '0);
		end
		n_code = $urandom_range(4, 40);
		for (k = 0; k < n_code; k++) begin
			r = $urandom_range(99);
			op = SYM_W'($urandom);
			if (r < 45) begin
				m = MODE_ENCODE;
				if (mtf_len != 0)
					op = mtf_list[IDX_W'($urandom_range(int'(mtf_len) - 1))];
			end else if (r < 85) begin
				m = MODE_DECODE;
				if (mtf_len != 0)
					op = SYM_W'($urandom_range(int'(mtf_len) - 1));
			end else if (r < 92) begin
				m = MODE_ENCODE;
			end else if (r < 97) begin
				m = MODE_DECODE;
			end else begin
				m = mode_t'($urandom_range(3));
			end
			send_word(m, op, k == n_code - 1, 1'b0, '0);
		end
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		code_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_codes.size() == 0) begin
				$display("%0t: unexpected word: value %0d status %0d last %0d",
					$time, value, status, last_out);
				mismatches++;
			end else begin
				want = pending_codes.pop_front();
				if (value !== want.value) begin
					$display("%0t: value expected %0d actual %0d", $time, want.value, value);
					mismatches++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatches++;
				end
				if (last_out !== want.last) begin
					$display("%0t: last_out expected %0d actual %0d", $time, want.last,
						last_out);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int    i;
		int    seq_no;
		int    phase;
		int    fill;
		code_t typed_code;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_ROWS; i++) begin
			typed_code = '{value: dir_rows[i].value, status: dir_rows[i].status,
				last: dir_rows[i].l};
			send_word(dir_rows[i].m, dir_rows[i].op, dir_rows[i].l, dir_rows[i].typed,
				typed_code);
		end

		phase = 0;
		seq_no = 0;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if (phase == 0 && sent >= RANDOM_WORDS / 3) begin
				drain_codes();
				send_idle_pct = 65;
				recv_stall_pct = 34;
				phase = 1;
			end else if (phase == 1 && sent >= 2 * RANDOM_WORDS / 3) begin
				drain_codes();
				send_idle_pct = 0;
				recv_stall_pct = 0;
				phase = 2;
			end else if ($urandom_range(7) == 0) begin
				drain_codes();
			end
			if (seq_no == 1 || $urandom_range(15) == 0)
				fill = ALPHABET_SIZE;
			else
				fill = $urandom_range(1, 24);
			code_sequence(fill);
			seq_no++;
		end

		in_valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_codes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
